// ===== sv/pte_pkg.sv =====
// Shared types and constants of the piece table edit engine.
// Used by pte_pmem, piece_table_edit_engine and pte_checker.
// Depends on nothing else.
package pte_pkg;

	localparam int MAX_PIECES = 64;
	localparam int ORIG_DEPTH = 65536;
	localparam int ADD_DEPTH  = 65536;

	localparam int PIDX_W  = $clog2(MAX_PIECES);
	localparam int PCNT_W  = $clog2(MAX_PIECES) + 1;
	localparam int TADDR_W = 16;
	localparam int TCNT_W  = 17;
	localparam int PSIZE_W = 17;
	localparam int POS_W   = 18;

	localparam int IN_W  = 32;
	localparam int OUT_W = 40;

	localparam logic [2:0] FUNC_CLEAR  = 3'd0;
	localparam logic [2:0] FUNC_LOAD   = 3'd1;
	localparam logic [2:0] FUNC_INSERT = 3'd2;
	localparam logic [2:0] FUNC_DELETE = 3'd3;
	localparam logic [2:0] FUNC_READ   = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_RANGE      = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_STORE_FULL = 2'd3;

	typedef struct packed {
		logic                src;
		logic [TADDR_W-1:0]  off;
		logic [PSIZE_W-1:0]  size;
	} piece_t;

	typedef struct packed {
		logic              en;
		logic [PIDX_W-1:0] addr;
		piece_t            data;
	} pwr_t;

endpackage

// ===== sv/piece_table_edit_engine.sv =====
// Clear, load, unused codes and operations refused for range or a full store go straight
// from decode to the result. An edit or read scans the pieces up to the one it touches; an
// edit then moves the descriptors behind that piece, so scan and shift together cover the
// table once. The engine takes one transaction at a time. Reset: arst_n clears the sequencer,
// the counts and the output valid at once; the stores and the piece memory are only read
// below their counts.
module piece_table_edit_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata from bit 0 up: func[2:0], position[20:3], char_in[28:21], zero fill.
	input  logic [pte_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata from bit 0 up: status[1:0], char_out[9:2], text_length[27:10],
	// piece_total[34:28], zero fill.
	output logic [pte_pkg::OUT_W-1:0] m_tdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_EDIT, S_FETCH, S_SHR, S_SHW,
		S_INS_A, S_INS_B, S_INS_C, S_SPL_A, S_SPL_B, S_CLOSE_RD, S_CLOSE_WR, S_DONE
	} state_t;

	state_t state_q;

	logic [2:0]                    func_q;
	logic [pte_pkg::POS_W-1:0]     pos_q;
	logic [7:0]                    ch_q;
	logic [1:0]                    status_q;
	logic [7:0]                    char_q;
	logic [pte_pkg::PCNT_W-1:0]    pcount_q;
	logic [pte_pkg::TCNT_W-1:0]    orig_cnt_q;
	logic [pte_pkg::TCNT_W-1:0]    add_cnt_q;
	logic [pte_pkg::POS_W-1:0]     len_q;
	logic [pte_pkg::POS_W-1:0]     base_q;
	logic [pte_pkg::PIDX_W-1:0]    scan_q;
	logic [pte_pkg::PIDX_W-1:0]    idx_q;
	logic [pte_pkg::PIDX_W-1:0]    k_q;
	logic [pte_pkg::PIDX_W-1:0]    sh_q;
	logic [pte_pkg::PIDX_W-1:0]    at_q;
	logic                          need2_q;
	logic [pte_pkg::PSIZE_W-1:0]   off_q;
	pte_pkg::piece_t               hit_q;

	logic [7:0] orig_mem [pte_pkg::ORIG_DEPTH];
	logic [7:0] add_mem  [pte_pkg::ADD_DEPTH];
	logic [7:0] orig_rd_q;
	logic [7:0] add_rd_q;

	pte_pkg::piece_t            rd_data;
	pte_pkg::pwr_t              pwr;
	logic [pte_pkg::PIDX_W-1:0] rd_addr;

	logic                          in_accept;
	logic [pte_pkg::POS_W-1:0]     scan_end;
	logic                          scan_hit;
	logic                          orig_full;
	logic                          add_full;
	logic                          need2;
	logic [pte_pkg::PCNT_W-1:0]    need_n;
	logic [pte_pkg::PIDX_W-1:0]    sh_n;
	logic [pte_pkg::TADDR_W-1:0]   text_addr;
	logic                          orig_we;
	logic                          add_we;
	logic [pte_pkg::TADDR_W-1:0]   off16;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;

	assign orig_full = (orig_cnt_q >= pte_pkg::TCNT_W'(pte_pkg::ORIG_DEPTH));
	assign add_full  = (add_cnt_q >= pte_pkg::TCNT_W'(pte_pkg::ADD_DEPTH));
	assign off16     = off_q[pte_pkg::TADDR_W-1:0];

	// The one shared adder and comparator: running base plus the current piece size.
	assign scan_end = base_q + pte_pkg::POS_W'(rd_data.size);
	assign scan_hit = (func_q == pte_pkg::FUNC_INSERT) ? (pos_q <= scan_end)
	                                                   : (pos_q < scan_end);

	// Insert splits the piece when the position falls strictly inside it.
	assign need2  = (off_q != '0) && (off_q < hit_q.size);
	assign need_n = need2 ? pte_pkg::PCNT_W'(2) : pte_pkg::PCNT_W'(1);
	assign sh_n   = need2_q ? pte_pkg::PIDX_W'(2) : pte_pkg::PIDX_W'(1);

	assign text_addr = hit_q.off + off16;

	// Text store writes happen only where the operation is known to succeed.
	assign orig_we = (state_q == S_DECODE) && (func_q == pte_pkg::FUNC_LOAD) && !orig_full;
	assign add_we  = ((state_q == S_DECODE) && (func_q == pte_pkg::FUNC_INSERT) && !add_full
	                  && (pcount_q == '0))
	              || ((state_q == S_EDIT) && (func_q == pte_pkg::FUNC_INSERT)
	                  && !(pcount_q + need_n > pte_pkg::PCNT_W'(pte_pkg::MAX_PIECES)));

	always_ff @(posedge clk) begin
		if (orig_we) begin
			orig_mem[orig_cnt_q[pte_pkg::TADDR_W-1:0]] <= ch_q;
		end
		if (add_we) begin
			add_mem[add_cnt_q[pte_pkg::TADDR_W-1:0]] <= ch_q;
		end
		orig_rd_q <= orig_mem[text_addr];
		add_rd_q  <= add_mem[text_addr];
	end

	// Read address of the piece memory follows the sequencer.
	always_comb begin
		case (state_q)
			S_SHR, S_SHW:           rd_addr = sh_q;
			S_CLOSE_RD, S_CLOSE_WR: rd_addr = sh_q + pte_pkg::PIDX_W'(1);
			default:                rd_addr = scan_q;
		endcase
	end

	// Piece memory write request for each sequencer step.
	always_comb begin
		pwr = '0;
		case (state_q)
			S_DECODE: begin
				if (func_q == pte_pkg::FUNC_LOAD && !orig_full) begin
					pwr.en   = 1'b1;
					pwr.data = '{src: 1'b0, off: '0, size: orig_cnt_q + 1'b1};
				end else if (func_q == pte_pkg::FUNC_INSERT && !add_full && pcount_q == '0) begin
					pwr.en   = 1'b1;
					pwr.data = '{src: 1'b1, off: add_cnt_q[pte_pkg::TADDR_W-1:0],
					              size: pte_pkg::PSIZE_W'(1)};
				end
			end
			S_EDIT: begin
				pwr.addr = idx_q;
				if (func_q == pte_pkg::FUNC_DELETE) begin
					if (off_q == '0 && hit_q.size != pte_pkg::PSIZE_W'(1)) begin
						pwr.en   = 1'b1;
						pwr.data = '{src: hit_q.src, off: hit_q.off + 1'b1,
						              size: hit_q.size - 1'b1};
					end else if (off_q != '0 && off_q == hit_q.size - 1'b1) begin
						pwr.en   = 1'b1;
						pwr.data = '{src: hit_q.src, off: hit_q.off, size: hit_q.size - 1'b1};
					end
				end
			end
			S_SHW: begin
				pwr.en   = 1'b1;
				pwr.addr = sh_q + sh_n;
				pwr.data = rd_data;
			end
			S_INS_A: begin
				pwr.en   = (off_q != '0);
				pwr.addr = k_q;
				pwr.data = '{src: hit_q.src, off: hit_q.off, size: off_q};
			end
			S_INS_B: begin
				pwr.en   = 1'b1;
				pwr.addr = k_q;
				pwr.data = '{src: 1'b1, off: add_cnt_q[pte_pkg::TADDR_W-1:0],
				              size: pte_pkg::PSIZE_W'(1)};
			end
			S_INS_C: begin
				pwr.en   = (off_q < hit_q.size);
				pwr.addr = k_q;
				pwr.data = '{src: hit_q.src, off: hit_q.off + off16, size: hit_q.size - off_q};
			end
			S_SPL_A: begin
				pwr.en   = 1'b1;
				pwr.addr = idx_q;
				pwr.data = '{src: hit_q.src, off: hit_q.off, size: off_q};
			end
			S_SPL_B: begin
				pwr.en   = 1'b1;
				pwr.addr = idx_q + pte_pkg::PIDX_W'(1);
				pwr.data = '{src: hit_q.src, off: hit_q.off + off16 + 1'b1,
				              size: hit_q.size - off_q - 1'b1};
			end
			S_CLOSE_WR: begin
				pwr.en   = 1'b1;
				pwr.addr = sh_q;
				pwr.data = rd_data;
			end
			default: begin
				pwr = '0;
			end
		endcase
	end

	pte_pmem u_pmem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (pwr)
	);

	// Sequencer with its counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pcount_q   <= '0;
			orig_cnt_q <= '0;
			add_cnt_q  <= '0;
			len_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			// In S_DONE the output register is refilled instead of emptied.
			if (m_tvalid && m_tready && state_q != S_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						func_q   <= s_tdata[2:0];
						pos_q    <= s_tdata[20:3];
						ch_q     <= s_tdata[28:21];
						status_q <= pte_pkg::ST_OK;
						char_q   <= '0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					base_q <= '0;
					scan_q <= '0;
					case (func_q)
						pte_pkg::FUNC_CLEAR: begin
							pcount_q   <= '0;
							orig_cnt_q <= '0;
							add_cnt_q  <= '0;
							len_q      <= '0;
							state_q    <= S_DONE;
						end
						pte_pkg::FUNC_LOAD: begin
							if (orig_full) begin
								status_q <= pte_pkg::ST_STORE_FULL;
							end else begin
								orig_cnt_q <= orig_cnt_q + 1'b1;
								pcount_q   <= pte_pkg::PCNT_W'(1);
								add_cnt_q  <= '0;
								len_q      <= pte_pkg::POS_W'(orig_cnt_q) + 1'b1;
							end
							state_q <= S_DONE;
						end
						pte_pkg::FUNC_INSERT: begin
							if (pos_q > len_q) begin
								pos_q <= len_q;
							end
							if (add_full) begin
								status_q <= pte_pkg::ST_STORE_FULL;
								state_q  <= S_DONE;
							end else if (pcount_q == '0) begin
								pcount_q  <= pte_pkg::PCNT_W'(1);
								add_cnt_q <= add_cnt_q + 1'b1;
								len_q     <= pte_pkg::POS_W'(1);
								state_q   <= S_DONE;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
						pte_pkg::FUNC_DELETE, pte_pkg::FUNC_READ: begin
							if (pos_q >= len_q) begin
								status_q <= pte_pkg::ST_RANGE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
						default: begin
							status_q <= pte_pkg::ST_OK;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (scan_hit) begin
						idx_q   <= scan_q;
						off_q   <= pte_pkg::PSIZE_W'(pos_q - base_q);
						hit_q   <= rd_data;
						state_q <= S_EDIT;
					end else begin
						base_q  <= scan_end;
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_EDIT: begin
					case (func_q)
						pte_pkg::FUNC_READ: begin
							state_q <= S_FETCH;
						end
						pte_pkg::FUNC_INSERT: begin
							if (pcount_q + need_n > pte_pkg::PCNT_W'(pte_pkg::MAX_PIECES)) begin
								status_q <= pte_pkg::ST_TABLE_FULL;
								state_q  <= S_DONE;
							end else begin
								need2_q <= need2;
								at_q    <= idx_q;
								sh_q    <= pte_pkg::PIDX_W'(pcount_q - 1'b1);
								state_q <= S_SHR;
							end
						end
						default: begin
							// Delete: trim the front, trim the back, drop, or split if the table has room.
							if (off_q == '0) begin
								if (hit_q.size == pte_pkg::PSIZE_W'(1)) begin
									sh_q    <= idx_q;
									state_q <= S_CLOSE_RD;
								end else begin
									len_q   <= len_q - 1'b1;
									state_q <= S_DONE;
								end
							end else if (off_q == hit_q.size - 1'b1) begin
								len_q   <= len_q - 1'b1;
								state_q <= S_DONE;
							end else if (pcount_q + 1'b1 >
							             pte_pkg::PCNT_W'(pte_pkg::MAX_PIECES)) begin
								status_q <= pte_pkg::ST_TABLE_FULL;
								state_q  <= S_DONE;
							end else begin
								need2_q <= 1'b0;
								at_q    <= idx_q + 1'b1;
								sh_q    <= pte_pkg::PIDX_W'(pcount_q - 1'b1);
								if (pcount_q > pte_pkg::PCNT_W'(idx_q) + 1'b1) begin
									state_q <= S_SHR;
								end else begin
									state_q <= S_SPL_A;
								end
							end
						end
					endcase
				end
				S_FETCH: begin
					char_q  <= hit_q.src ? add_rd_q : orig_rd_q;
					state_q <= S_DONE;
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					if (sh_q == at_q) begin
						k_q     <= idx_q;
						state_q <= (func_q == pte_pkg::FUNC_INSERT) ? S_INS_A : S_SPL_A;
					end else begin
						sh_q    <= sh_q - 1'b1;
						state_q <= S_SHR;
					end
				end
				S_INS_A: begin
					pcount_q <= pcount_q + (need2_q ? pte_pkg::PCNT_W'(2) : pte_pkg::PCNT_W'(1));
					if (off_q != '0) begin
						k_q <= k_q + 1'b1;
					end
					state_q <= S_INS_B;
				end
				S_INS_B: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_INS_C;
				end
				S_INS_C: begin
					add_cnt_q <= add_cnt_q + 1'b1;
					len_q     <= len_q + 1'b1;
					state_q   <= S_DONE;
				end
				S_SPL_A: begin
					pcount_q <= pcount_q + 1'b1;
					state_q  <= S_SPL_B;
				end
				S_SPL_B: begin
					len_q   <= len_q - 1'b1;
					state_q <= S_DONE;
				end
				S_CLOSE_RD: begin
					if (pte_pkg::PCNT_W'(sh_q) + 1'b1 < pcount_q) begin
						state_q <= S_CLOSE_WR;
					end else begin
						pcount_q <= pcount_q - 1'b1;
						len_q    <= len_q - 1'b1;
						state_q  <= S_DONE;
					end
				end
				S_CLOSE_WR: begin
					sh_q    <= sh_q + 1'b1;
					state_q <= S_CLOSE_RD;
				end
				S_DONE: begin
					// The result leaves only when the output register is free.
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {5'b0, pcount_q, len_q, char_q, status_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/pte_pmem.sv =====
// Piece descriptor memory: one write port and one registered read port.
// Depends on pte_pkg for the descriptor and write request types.
module pte_pmem (
	input  logic                          clk,
	input  logic [pte_pkg::PIDX_W-1:0]    rd_addr,
	output pte_pkg::piece_t               rd_data,
	input  pte_pkg::pwr_t                 wr
);

	pte_pkg::piece_t mem [pte_pkg::MAX_PIECES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/pte_checker.sv =====
// Port-level checks on the piece table edit engine, bound to its top level.
// Depends on pte_pkg for field widths and status codes.
module pte_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pte_pkg::OUT_W-1:0] m_tdata
);

	// A result that is held back keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The engine works on one transaction at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A failed operation never returns a character.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != pte_pkg::ST_OK |-> m_tdata[9:2] == 8'd0)
		else $error("character returned with failing status");

	// The piece count never exceeds the table size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:28] <= pte_pkg::PCNT_W'(pte_pkg::MAX_PIECES))
		else $error("piece total beyond table size");

endmodule

bind piece_table_edit_engine pte_checker u_pte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
